// ----- hdl/ptw_pkg.sv -----
// Shared types and constants for the page table walker with TLB.
// Depends on nothing; every module of the block imports it.
package ptw_pkg;

  localparam int unsigned MemWords   = 8192;
  localparam int unsigned MemAw      = $clog2(MemWords);
  localparam int unsigned TlbEntries = 16;
  localparam int unsigned TlbIw      = (TlbEntries > 1) ? $clog2(TlbEntries) : 1;

  localparam logic [2:0] OP_TRANSLATE   = 3'd0;
  localparam logic [2:0] OP_WRITE       = 3'd1;
  localparam logic [2:0] OP_FLUSH_ALL   = 3'd2;
  localparam logic [2:0] OP_FLUSH_ASID  = 3'd3;
  localparam logic [2:0] OP_FLUSH_PAGE  = 3'd4;

  localparam logic [1:0] CFG_SV48       = 2'd0;
  localparam logic [1:0] CFG_ROOT       = 2'd1;
  localparam logic [1:0] CFG_ASID       = 2'd2;
  localparam logic [1:0] CFG_MEM_BASE   = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] virt_addr;
    logic [3:0]  need_bits;
    logic [15:0] flush_asid;
    logic [55:0] write_addr;
    logic [63:0] write_data;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] phys_addr;
    logic        tlb_hit;
  } out_t;

endpackage

// ----- hdl/page_table_walker_with_tlb_top.sv -----
// Top level of the page table walker with TLB: sequencer, TLB and table memory.
// Depends on ptw_pkg.
//
//  channel | signals                        | direction
//  in      | in_valid_i/in_ready_o/in_data_i  | item in
//  out     | out_valid_o/out_ready_i/out_data_o | result out
//  cfg     | cfg_we_i/cfg_idx_i/cfg_wdata_i   | register write
//
// A TLB hit, write or flush finishes in the lookup state; a walk adds one
// table memory read and one PTE check per level, three levels in Sv39 and
// four in Sv48. The single table memory read port sets that pace.
// Reset clears TLB valid bits, victim pointer and registers at once; sets Sv48.
// A new item is taken only once the previous result has been transferred.
module page_table_walker_with_tlb_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptw_pkg::in_t        in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptw_pkg::out_t       out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [55:0]         cfg_wdata_i
);
  import ptw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_ADDR = 4'b0100,
    S_PTE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic        sv48_q;
  logic [55:0] root_q, base_cfg_q;
  logic [15:0] asid_q;

  in_t         req_q;
  out_t        out_q;
  out_t        look_res;
  logic        out_valid_q;

  logic [63:0] walk_base_q;
  logic [1:0]  sh_q;

  logic [63:0] mem_q [MemWords];
  logic [63:0] rdata_q;
  logic [MemAw-1:0] rd_idx;
  logic        rd_en;

  logic        tlb_valid_q [TlbEntries];
  logic [47:0] tlb_page_q  [TlbEntries];
  logic [15:0] tlb_space_q [TlbEntries];
  logic [63:0] tlb_entry_q [TlbEntries];
  logic [TlbIw-1:0] victim_q;

  logic [47:0] vpn;
  logic        hit;
  logic [63:0] hit_pte;
  logic [3:0]  want;
  logic [63:0] woff, aoff, walk_addr;
  logic [8:0]  vidx;
  logic        fill;

  assign vpn  = req_q.virt_addr[59:12];
  assign want = req_q.need_bits | 4'd1;
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    hit = 1'b0;
    hit_pte = '0;
    for (int i = TlbEntries - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && tlb_page_q[i] == vpn && tlb_space_q[i] == asid_q) begin
        hit = 1'b1;
        hit_pte = tlb_entry_q[i];
      end
    end
  end

  always_comb begin
    case (sh_q)
      2'd3:    vidx = req_q.virt_addr[47:39];
      2'd2:    vidx = req_q.virt_addr[38:30];
      2'd1:    vidx = req_q.virt_addr[29:21];
      default: vidx = req_q.virt_addr[20:12];
    endcase
  end

  // Offsets into the store wrap at 64 bits, as the physical address math does.
  assign woff      = {8'd0, req_q.write_addr} - {8'd0, base_cfg_q};
  assign walk_addr = walk_base_q + {52'd0, vidx, 3'd0};
  assign aoff      = walk_addr - {8'd0, base_cfg_q};
  assign rd_idx    = aoff[MemAw+2:3];
  assign rd_en     = (state_q == S_ADDR);
  assign fill      = (state_q == S_PTE) && rdata_q[0] && (sh_q == 2'd0);

  // Result of an item that finishes in the lookup cycle.
  always_comb begin
    look_res = '0;
    case (req_q.operation)
      OP_TRANSLATE: begin
        look_res.tlb_hit = hit;
        if (hit && (hit_pte[3:0] & want) == want) begin
          look_res.ok = 1'b1;
          look_res.phys_addr = {hit_pte[61:10], req_q.virt_addr[11:0]};
        end
      end
      OP_WRITE:     look_res.ok = (woff[63:MemAw+3] == '0);
      OP_FLUSH_ALL, OP_FLUSH_ASID, OP_FLUSH_PAGE: look_res.ok = 1'b1;
      default:      look_res = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i && in_ready_o) state_d = S_LOOK;
      S_LOOK:  if (req_q.operation == OP_TRANSLATE && !hit) state_d = S_ADDR;
               else state_d = S_IDLE;
      S_ADDR:  if (aoff[63:MemAw+3] == '0) state_d = S_PTE;
               else state_d = S_IDLE;
      S_PTE:   if (rdata_q[0] && sh_q != 2'd0) state_d = S_ADDR;
               else state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      sv48_q      <= 1'b1;
      root_q      <= '0;
      asid_q      <= '0;
      base_cfg_q  <= '0;
      victim_q    <= '0;
      for (int i = 0; i < TlbEntries; i++) tlb_valid_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SV48:     sv48_q     <= cfg_wdata_i[0];
          CFG_ROOT:     root_q     <= cfg_wdata_i;
          CFG_ASID:     asid_q     <= cfg_wdata_i[15:0];
          CFG_MEM_BASE: base_cfg_q <= cfg_wdata_i;
          default:      ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == S_LOOK && !(req_q.operation == OP_TRANSLATE && !hit))
        out_valid_q <= 1'b1;
      if (state_q == S_ADDR && aoff[63:MemAw+3] != '0) out_valid_q <= 1'b1;
      if (state_q == S_PTE && !(rdata_q[0] && sh_q != 2'd0)) out_valid_q <= 1'b1;
      if (state_q == S_LOOK) begin
        for (int i = 0; i < TlbEntries; i++) begin
          case (req_q.operation)
            OP_FLUSH_ALL:  tlb_valid_q[i] <= 1'b0;
            OP_FLUSH_ASID: if (tlb_space_q[i] == req_q.flush_asid) tlb_valid_q[i] <= 1'b0;
            OP_FLUSH_PAGE: if (tlb_space_q[i] == req_q.flush_asid && tlb_page_q[i] == vpn)
                             tlb_valid_q[i] <= 1'b0;
            default:       ;
          endcase
        end
      end
      if (fill) begin
        tlb_valid_q[victim_q] <= 1'b1;
        victim_q <= (victim_q == TlbIw'(TlbEntries - 1)) ? '0 : victim_q + 1'b1;
      end
    end
  end

  // Payload, TLB contents and the table memory need no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
    if (rd_en) rdata_q <= mem_q[rd_idx];
    if (fill) begin
      tlb_page_q[victim_q]  <= vpn;
      tlb_space_q[victim_q] <= asid_q;
      tlb_entry_q[victim_q] <= rdata_q;
    end
    case (state_q)
      S_LOOK: begin
        out_q <= look_res;
        walk_base_q <= {8'd0, root_q[55:12], 12'd0};
        sh_q <= sv48_q ? 2'd3 : 2'd2;
        if (req_q.operation == OP_WRITE && woff[63:MemAw+3] == '0)
          mem_q[woff[MemAw+2:3]] <= req_q.write_data;
      end
      S_ADDR: out_q <= '0;
      S_PTE: begin
        walk_base_q <= {rdata_q[61:10], 12'd0};
        sh_q <= sh_q - 2'd1;
        if (fill && (rdata_q[3:0] & want) == want)
          out_q <= {1'b1, rdata_q[61:10], req_q.virt_addr[11:0], 1'b0};
      end
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE && !out_valid_q)
    else $error("ready while busy");
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_LOOK)
    else $error("transfer did not start lookup");
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.ok) |-> out_q.phys_addr == '0)
    else $error("fault with nonzero address");
  a_fill_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill |-> req_q.operation == OP_TRANSLATE)
    else $error("TLB fill outside a walk");

endmodule
